FILE: rtl/hpc_pkg.sv
package hpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_VERTS_DEF = 8;
  localparam int GUARD_W = 18;
  localparam logic [GUARD_W-1:0] GUARD_RESET = 18'd65601;
  localparam int NUM_COORDS = 6;
  localparam int MUL_AW = 33;
  localparam int MUL_BW = GUARD_W + 1;
  localparam int DIST_W = MUL_AW + MUL_BW;
  localparam int DIV_W = DIST_W + 1;

  localparam logic [2:0] CI_X = 3'd0;
  localparam logic [2:0] CI_Y = 3'd1;
  localparam logic [2:0] CI_Z = 3'd2;
  localparam logic [2:0] CI_W = 3'd3;
  localparam logic [2:0] CI_U = 3'd4;
  localparam logic [2:0] CI_V = 3'd5;

  typedef logic [NUM_COORDS-1:0][31:0] vtx_t;

  typedef enum logic [2:0] {
    PL_LEFT, PL_RIGHT, PL_TOP, PL_BOTTOM, PL_NEAR, PL_FAR
  } plane_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_FETCH, S_LATCH, S_DIST, S_DECIDE, S_DIV, S_LERP, S_LACC,
    S_PUSHI, S_PUSHE, S_NEXT, S_ERD, S_EOUT, S_EEMPTY
  } state_t;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic signed [31:0] in_u;
    logic signed [31:0] in_v;
    logic in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic out_last;
    logic out_empty;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/hpc_vbuf.sv
module hpc_vbuf import hpc_pkg::*; #(
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  vtx_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output vtx_t          rd_data
);

  vtx_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/hpc_mul.sv
module hpc_mul import hpc_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_AW-1:0] a,
  input  logic signed [MUL_BW-1:0] b,
  output logic signed [DIST_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= DIST_W'(a * b);
  end

endmodule

FILE: rtl/hpc_div.sv
module hpc_div import hpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic [FRAC_BITS:0] q
);

  localparam int CNTW = $clog2(FRAC_BITS);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic             busy;
  logic [CNTW-1:0]  cnt;
  logic [DIV_W-1:0] r;
  logic [DIV_W-1:0] dv;
  logic [FRAC_BITS:0] qr;
  logic [DIV_W-1:0] r1;
  logic [DIV_W-1:0] r2;
  logic             ge0;
  logic [DIV_W:0]   rs;
  logic             ge;

  always_comb begin
    ge0 = req.num >= req.den;
    r1  = ge0 ? req.num - req.den : req.num;
    r2  = (r1 >= req.den) ? '0 : r1;
    rs  = {r, 1'b0};
    ge  = rs >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dv <= req.den;
      r  <= r2;
      qr <= (FRAC_BITS+1)'(ge0);
    end else if (busy) begin
      r  <= ge ? DIV_W'(rs - {1'b0, dv}) : DIV_W'(rs);
      qr <= {qr[FRAC_BITS-1:0], ge};
    end
  end

  assign q = (qr > ONE) ? ONE : qr;

endmodule

FILE: rtl/homogeneous_polygon_clipper.sv
// vertex load: one cycle per vertex, zero results until the last vertex
// clipping: six passes on one shared multiplier and one 16-step divider;
// each pass fetches and tests every edge and interpolates each crossing; empty passes skip
// emit: each result vertex is read from the buffer, then sent; held while out_ready is low
// in_ready is low while a polygon is clipped and emitted
// rst (synchronous) clears counts and sequencer, restores guard; buffers hold junk
module homogeneous_polygon_clipper import hpc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [GUARD_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);

  state_t state, state_next;
  plane_t plane;
  logic [CW-1:0] n, dn;
  logic [IW-1:0] i;
  logic [2:0] k;
  logic bank, init;
  logic [GUARD_W-1:0] guard;
  vtx_t vs, ve, nv;
  logic signed [DIST_W-1:0] ds, de;
  logic [FRAC_BITS:0] t;

  logic wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  vtx_t wr_data, rd_data;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [DIST_W-1:0] mul_p;
  div_req_t div_req;
  logic div_done;
  logic [FRAC_BITS:0] div_q;

  logic in_fire, slot_free, s_in, e_in, crossing;
  logic emit;
  logic [CW-1:0] nm1;
  logic signed [MUL_AW-1:0] cpos, csel;
  logic signed [DIST_W-1:0] d;
  logic signed [DIV_W-1:0] den;
  logic [DIV_W-1:0] ds_abs;
  logic last_edge;
  vtx_t in_vtx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && (state == S_EOUT || state == S_EEMPTY);
  assign nm1       = n - 1'b1;
  assign last_edge = (CW'(i) == nm1);
  assign in_vtx    = {in_data.in_v, in_data.in_u, in_data.in_w,
                      in_data.in_z, in_data.in_y, in_data.in_x};

  always_comb begin
    s_in     = ds[DIST_W-1] || (ds == '0);
    e_in     = de[DIST_W-1] || (de == '0);
    crossing = s_in != e_in;
    den      = DIV_W'(ds) - DIV_W'(de);
    ds_abs   = ds[DIST_W-1] ? DIV_W'(-DIV_W'(ds)) : DIV_W'(ds);
    unique case (plane)
      PL_LEFT, PL_RIGHT: cpos = {ve[CI_X][31], ve[CI_X]};
      PL_TOP, PL_BOTTOM: cpos = {ve[CI_Y][31], ve[CI_Y]};
      default:           cpos = {ve[CI_Z][31], ve[CI_Z]};
    endcase
    unique case (plane)
      PL_RIGHT, PL_BOTTOM, PL_NEAR: csel = -cpos;
      default:                      csel = cpos;
    endcase
    d = (DIST_W'(csel) <<< FRAC_BITS) - mul_p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en   = 1'b0;
    wr_addr = {~bank, dn[IW-1:0]};
    wr_data = ve;
    rd_en   = 1'b0;
    rd_addr = {bank, i};
    mul_a   = {ve[k][31], ve[k]} - {vs[k][31], vs[k]};
    mul_b   = MUL_BW'(t);
    div_req = '{start: 1'b0, num: ds_abs, den: (den[DIV_W-1] ? -den : den)};
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          wr_en   = n < MAXV;
          wr_addr = {1'b0, n[IW-1:0]};
          wr_data = in_vtx;
          if (in_data.in_last) state_next = S_PASS;
        end
      end
      S_PASS: state_next = (n == '0) ? S_NEXT : S_FETCH;
      S_FETCH: begin
        rd_en = 1'b1;
        rd_addr = {bank, init ? nm1[IW-1:0] : i};
        state_next = S_LATCH;
      end
      S_LATCH: begin
        mul_a = {rd_data[CI_W][31], rd_data[CI_W]};
        mul_b = {1'b0, guard};
        state_next = S_DIST;
      end
      S_DIST: state_next = init ? S_FETCH : S_DECIDE;
      S_DECIDE: begin
        if (crossing && den != '0) begin
          div_req.start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_PUSHE;
        end
      end
      S_DIV: if (div_done) state_next = S_LERP;
      S_LERP: state_next = S_LACC;
      S_LACC: state_next = (k == CI_V) ? S_PUSHI : S_LERP;
      S_PUSHI: begin
        wr_en = dn < MAXV;
        wr_data = nv;
        state_next = S_PUSHE;
      end
      S_PUSHE: begin
        wr_en = e_in && (dn < MAXV);
        state_next = last_edge ? S_NEXT : S_FETCH;
      end
      S_NEXT: begin
        if (plane == PL_FAR) state_next = (dn == '0) ? S_EEMPTY : S_ERD;
        else state_next = S_PASS;
      end
      S_ERD: begin
        rd_en = 1'b1;
        state_next = S_EOUT;
      end
      S_EOUT: if (slot_free) state_next = last_edge ? S_IDLE : S_ERD;
      S_EEMPTY: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      dn <= '0;
      i <= '0;
      k <= '0;
      bank <= 1'b0;
      init <= 1'b0;
      plane <= PL_LEFT;
      guard <= GUARD_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) guard <= cfg_data;
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire && n < MAXV) n <= n + 1'b1;
          plane <= PL_LEFT;
          bank <= 1'b0;
        end
        S_PASS: begin
          dn <= '0;
          init <= 1'b1;
          i <= '0;
        end
        S_DIST: begin
          if (init) begin
            vs <= ve;
            ds <= d;
            init <= 1'b0;
          end else begin
            de <= d;
          end
        end
        S_LATCH: ve <= rd_data;
        S_DIV: begin
          t <= div_q;
          k <= '0;
        end
        S_LACC: begin
          nv[k] <= vs[k] + mul_p[FRAC_BITS+31:FRAC_BITS];
          k <= k + 1'b1;
        end
        S_PUSHI: if (dn < MAXV) dn <= dn + 1'b1;
        S_PUSHE: begin
          if (e_in && dn < MAXV) dn <= dn + 1'b1;
          vs <= ve;
          ds <= de;
          i <= i + 1'b1;
        end
        S_NEXT: begin
          n <= dn;
          bank <= ~bank;
          i <= '0;
          if (plane != PL_FAR) plane <= plane_t'(plane + 3'd1);
        end
        S_EOUT: begin
          if (slot_free) begin
            out_data <= '{out_x: rd_data[CI_X], out_y: rd_data[CI_Y],
                          out_z: rd_data[CI_Z], out_w: rd_data[CI_W],
                          out_u: rd_data[CI_U], out_v: rd_data[CI_V],
                          out_last: last_edge, out_empty: 1'b0};
            i <= i + 1'b1;
            if (last_edge) n <= '0;
          end
        end
        S_EEMPTY: begin
          if (slot_free) begin
            out_data <= '{out_empty: 1'b1, default: '0};
            n <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  hpc_vbuf #(.AW(AW)) u_vbuf (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  hpc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  hpc_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .q(div_q));

  // clip output never grows past the buffer
  a_dn_bound: assert property (@(posedge clk) disable iff (rst) dn <= MAXV)
    else $error("clip count overflow");

  // interpolation factor stays within one
  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_q <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
    else $error("interpolation factor above one");

  // an empty request only when the final pass left nothing
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_EEMPTY) |-> (n == '0))
    else $error("empty request with vertices left");

  // emitting ends with the counts cleared for the next polygon
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EOUT && slot_free && last_edge) |=> (n == '0 && state == S_IDLE))
    else $error("counts not cleared after emit");

endmodule

FILE: dv/homogeneous_polygon_clipper_test.sv
`timescale 1ns / 1ps

module homogeneous_polygon_clipper_test;
  import hpc_pkg::*;

  localparam int MAXV = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    longint c[6];
  } pvtx_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [GUARD_W-1:0] cfg_data;

  homogeneous_polygon_clipper u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  pvtx_t poly_verts[MAXV];
  int poly_count;
  longint guard;
  out_item_t clipped_q[$];

  int errors;
  int idle_cycles;
  bit stall_enable;
  int n_requests;
  int n_vertices_out;
  int n_empty;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint plane_distance(pvtx_t p, int plane);
    longint c;
    case (plane)
      PL_LEFT:   c = p.c[0];
      PL_RIGHT:  c = -p.c[0];
      PL_TOP:    c = p.c[1];
      PL_BOTTOM: c = -p.c[1];
      PL_NEAR:   c = -p.c[2];
      default:   c = p.c[2];
    endcase
    return c * (longint'(1) << FRAC_BITS) - p.c[3] * guard;
  endfunction

  function automatic longint edge_fraction(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = n;
    if (r >= d) begin
      r -= d;
      q = 1;
    end
    if (r >= d) r = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    if (q > (longint'(1) << FRAC_BITS)) q = longint'(1) << FRAC_BITS;
    return q;
  endfunction

  function automatic longint floor_frac(longint p);
    return p >>> FRAC_BITS;
  endfunction

  function automatic void clip_plane(ref pvtx_t src[MAXV], input int n, ref pvtx_t dst[MAXV],
                                     output int dn, input int plane);
    pvtx_t s;
    pvtx_t e;
    pvtx_t nv;
    longint ds;
    longint de;
    longint den;
    longint t;
    dn = 0;
    if (n <= 0) return;
    s = src[n-1];
    ds = plane_distance(s, plane);
    for (int i = 0; i < n; i++) begin
      e = src[i];
      de = plane_distance(e, plane);
      if ((ds <= 0) != (de <= 0)) begin
        den = ds - de;
        if (den != 0) begin
          t = edge_fraction(ds < 0 ? -ds : ds, den < 0 ? -den : den);
          for (int k = 0; k < 6; k++)
            nv.c[k] = s.c[k] + floor_frac((e.c[k] - s.c[k]) * t);
          if (dn < MAXV) begin
            dst[dn] = nv;
            dn++;
          end
        end
      end
      if (de <= 0 && dn < MAXV) begin
        dst[dn] = e;
        dn++;
      end
      s = e;
      ds = de;
    end
  endfunction

  // collect a vertex; on the closing one clip and queue the surviving vertices or an empty marker
  function automatic void predict_clip(in_item_t it);
    pvtx_t v;
    pvtx_t pong[MAXV];
    int pong_n;
    out_item_t o;
    v.c[0] = it.in_x;
    v.c[1] = it.in_y;
    v.c[2] = it.in_z;
    v.c[3] = it.in_w;
    v.c[4] = it.in_u;
    v.c[5] = it.in_v;
    if (poly_count < MAXV) begin
      poly_verts[poly_count] = v;
      poly_count++;
    end
    if (!it.in_last) return;
    for (int p = 0; p < 6; p += 2) begin
      clip_plane(poly_verts, poly_count, pong, pong_n, p);
      clip_plane(pong, pong_n, poly_verts, poly_count, p + 1);
    end
    if (poly_count == 0) begin
      o = '0;
      o.out_empty = 1'b1;
      clipped_q.push_back(o);
    end else begin
      for (int i = 0; i < poly_count; i++) begin
        o.out_x = poly_verts[i].c[0];
        o.out_y = poly_verts[i].c[1];
        o.out_z = poly_verts[i].c[2];
        o.out_w = poly_verts[i].c[3];
        o.out_u = poly_verts[i].c[4];
        o.out_v = poly_verts[i].c[5];
        o.out_last = (i == poly_count - 1);
        o.out_empty = 1'b0;
        clipped_q.push_back(o);
      end
    end
    poly_count = 0;
  endfunction

  task automatic random_gap();
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic send_vertex(in_item_t it);
    random_gap();
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_clip(it);
    n_requests++;
    @(negedge clk);
  endtask

  task automatic write_guard(logic [GUARD_W-1:0] g);
    in_valid <= 1'b0;
    while (clipped_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    guard = g;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_vertex(int x, int y, int z, int w, bit last);
    in_item_t it;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    it.in_w = w;
    it.in_u = $urandom;
    it.in_v = $urandom;
    it.in_last = last;
    return it;
  endfunction

  // coordinates mostly near the view volume so that edges cross planes
  function automatic int near_coord(int w);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 2*w) - w;
      default: return int'($urandom_range(0, 4*w)) - 2*w;
    endcase
  endfunction

  task automatic send_random_polygon();
    int n;
    int w;
    in_item_t it;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 11) : $urandom_range(3, 5);
    w = $urandom_range(1, 8) << 16;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) w = $urandom;
      it = make_vertex(near_coord(w), near_coord(w), near_coord(w), w, i == n - 1);
      send_vertex(it);
    end
  endtask

  task automatic test_directed();
    int one;
    one = 1 << 16;
    // fully inside triangle
    send_vertex(make_vertex(0, 0, 0, one, 0));
    send_vertex(make_vertex(one/2, 0, 0, one, 0));
    send_vertex(make_vertex(0, one/2, 0, one, 1));
    // triangle crossing left, right, top and near planes
    send_vertex(make_vertex(-3*one, 0, 0, one, 0));
    send_vertex(make_vertex(3*one, one/4, 0, one, 0));
    send_vertex(make_vertex(0, 3*one, -3*one, one, 1));
    // fully outside gives the empty marker
    send_vertex(make_vertex(5*one, 5*one, 0, one, 0));
    send_vertex(make_vertex(6*one, 5*one, 0, one, 0));
    send_vertex(make_vertex(5*one, 6*one, 0, one, 1));
    // field extremes
    send_vertex(make_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0));
    send_vertex(make_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 0));
    send_vertex(make_vertex(-1, -1, -1, -1, 1));
    // single vertex closing polygon
    send_vertex(make_vertex(0, 0, 0, one, 1));
    // more than eight vertices: extras dropped, the last still closes
    for (int i = 0; i < 10; i++)
      send_vertex(make_vertex((i % 3 - 1) * 2 * one, (i % 2) ? 3*one : -3*one, 0, one, i == 9));
  endtask

  task automatic test_guard_settings();
    write_guard(18'd0);
    repeat (15) send_random_polygon();
    write_guard(18'h3ffff);
    repeat (15) send_random_polygon();
    write_guard(18'd131072);
    repeat (15) send_random_polygon();
    write_guard(18'd65536);
  endtask

  task automatic test_random_polygons();
    while (n_requests < 250) send_random_polygon();
  endtask

  task automatic test_no_stall();
    stall_enable = 1'b0;
    while (n_requests < 290) send_random_polygon();
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (clipped_q.size() == 0) begin
        $error("unexpected vertex out x=%0d", out_data.out_x);
        errors++;
      end else begin
        out_item_t e;
        e = clipped_q.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x expected %0d actual %0d", e.out_x, out_data.out_x); errors++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y expected %0d actual %0d", e.out_y, out_data.out_y); errors++;
        end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z expected %0d actual %0d", e.out_z, out_data.out_z); errors++;
        end
        if (out_data.out_w !== e.out_w) begin
          $error("out_w expected %0d actual %0d", e.out_w, out_data.out_w); errors++;
        end
        if (out_data.out_u !== e.out_u) begin
          $error("out_u expected %0d actual %0d", e.out_u, out_data.out_u); errors++;
        end
        if (out_data.out_v !== e.out_v) begin
          $error("out_v expected %0d actual %0d", e.out_v, out_data.out_v); errors++;
        end
        if (out_data.out_last !== e.out_last) begin
          $error("out_last expected %0b actual %0b", e.out_last, out_data.out_last); errors++;
        end
        if (out_data.out_empty !== e.out_empty) begin
          $error("out_empty expected %0b actual %0b", e.out_empty, out_data.out_empty);
          errors++;
        end
        if (e.out_empty) n_empty++;
        else n_vertices_out++;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        if (burst == 0) out_ready <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    poly_count = 0;
    guard = GUARD_RESET;
    stall_enable = 1'b1;
    n_requests = 0;
    n_vertices_out = 0;
    n_empty = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_guard_settings();
    test_random_polygons();
    test_no_stall();
    in_valid <= 1'b0;
    while (clipped_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d vertex requests, %0d clipped vertices, %0d empty polygons",
             n_requests, n_vertices_out, n_empty);
    $display("guard factor swept over zero, unity, twice and the field maximum");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
